// File: sv/wdc_pkg.sv
// shared types, constants and calendar helpers of the workday counter
package wdc_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned MASK_W  = 7;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned Q100_W  = 8;   // year / 100 for any 14-bit year
  localparam int unsigned SUM_W   = 15;  // weekday sum before reduction mod 7
  localparam int unsigned Q7_W    = 12;

  // reciprocal constants: x / 100 = (x * 5243) >> 19 for x < 2^14,
  // x / 7 = (x * 149797) >> 20 for x < 2^15
  localparam logic [12:0] RECIP_100       = 13'd5243;
  localparam int unsigned RECIP_100_SHIFT = 19;
  localparam logic [17:0] RECIP_7         = 18'd149797;
  localparam int unsigned RECIP_7_SHIFT   = 20;

  localparam logic [MASK_W-1:0]  WEEKEND_RESET = 7'd96;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
  localparam logic [WDAY_W-1:0]  WDAY_SAT      = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QUOT_START,
    ST_CHECK_START,
    ST_QUOT_END,
    ST_CHECK_END,
    ST_QUOT_WDAY,
    ST_SUM_WDAY,
    ST_MOD_WDAY,
    ST_INIT_WALK,
    ST_WALK,
    ST_FINISH
  } ctrl_state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_QUOT_START,
    CMD_CHECK_START,
    CMD_QUOT_END,
    CMD_CHECK_END,
    CMD_QUOT_WDAY,
    CMD_SUM_WDAY,
    CMD_MOD_WDAY,
    CMD_INIT_WALK,
    CMD_STEP,
    CMD_FINISH
  } dp_cmd_e;

  typedef struct packed {
    logic bad;        // a date of the current word failed its check
    logic walk_done;  // walk reached the end date, or the span is empty
    logic out_free;   // output register can take a result this cycle
  } dp_status_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // (31 * mm) / 12 with mm counted from march
  function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] off;
    case (m)
      4'd1:  off = 5'd28;
      4'd2:  off = 5'd31;
      4'd3:  off = 5'd2;
      4'd4:  off = 5'd5;
      4'd5:  off = 5'd7;
      4'd6:  off = 5'd10;
      4'd7:  off = 5'd12;
      4'd8:  off = 5'd15;
      4'd9:  off = 5'd18;
      4'd10: off = 5'd20;
      4'd11: off = 5'd23;
      4'd12: off = 5'd25;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

endpackage

// File: sv/wdc_if.sv
// valid/ready channels for date pairs and workday results

interface wdc_date_if;
  import wdc_pkg::*;
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  start_year;
  logic [MONTH_W-1:0] start_month;
  logic [DAY_W-1:0]   start_day;
  logic [YEAR_W-1:0]  end_year;
  logic [MONTH_W-1:0] end_month;
  logic [DAY_W-1:0]   end_day;
  logic               include_end;

  modport source (
    output valid, start_year, start_month, start_day,
    output end_year, end_month, end_day, include_end,
    input  ready
  );
  modport sink (
    input  valid, start_year, start_month, start_day,
    input  end_year, end_month, end_day, include_end,
    output ready
  );
endinterface

interface wdc_result_if;
  import wdc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] work_days;
  logic               bad_date;

  modport source (
    output valid, work_days, bad_date,
    input  ready
  );
  modport sink (
    input  valid, work_days, bad_date,
    output ready
  );
endinterface

// File: sv/wdc_ctrl.sv
// sequencer for date check, weekday computation and the day walk
module wdc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wdc_pkg::dp_status_t status_i,
  output wdc_pkg::dp_cmd_e    cmd_o
);
  import wdc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:        if (in_valid_i) state_d = ST_QUOT_START;
      ST_QUOT_START:  state_d = ST_CHECK_START;
      ST_CHECK_START: state_d = ST_QUOT_END;
      ST_QUOT_END:    state_d = ST_CHECK_END;
      ST_CHECK_END:   state_d = ST_QUOT_WDAY;
      ST_QUOT_WDAY:   state_d = status_i.bad ? ST_FINISH : ST_SUM_WDAY;
      ST_SUM_WDAY:    state_d = ST_MOD_WDAY;
      ST_MOD_WDAY:    state_d = ST_INIT_WALK;
      ST_INIT_WALK:   state_d = ST_WALK;
      ST_WALK:        if (status_i.walk_done) state_d = ST_FINISH;
      ST_FINISH:      if (status_i.out_free) state_d = ST_IDLE;
      default:        state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o = CMD_LOAD;
      end
      ST_QUOT_START:  cmd_o = CMD_QUOT_START;
      ST_CHECK_START: cmd_o = CMD_CHECK_START;
      ST_QUOT_END:    cmd_o = CMD_QUOT_END;
      ST_CHECK_END:   cmd_o = CMD_CHECK_END;
      ST_QUOT_WDAY:   if (!status_i.bad) cmd_o = CMD_QUOT_WDAY;
      ST_SUM_WDAY:    cmd_o = CMD_SUM_WDAY;
      ST_MOD_WDAY:    cmd_o = CMD_MOD_WDAY;
      ST_INIT_WALK:   cmd_o = CMD_INIT_WALK;
      ST_WALK:        if (!status_i.walk_done) cmd_o = CMD_STEP;
      ST_FINISH:      if (status_i.out_free) cmd_o = CMD_FINISH;
      default:        cmd_o = CMD_NONE;
    endcase
  end

endmodule

// File: sv/wdc_datapath.sv
// date registers, reciprocal multipliers, calendar stepper and result register
module wdc_datapath #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wdc_pkg::dp_cmd_e              cmd_i,
  output wdc_pkg::dp_status_t           status_o,
  input  logic                          cfg_we_i,
  input  logic [wdc_pkg::MASK_W-1:0]    cfg_wdata_i,
  input  logic [wdc_pkg::YEAR_W-1:0]    start_year_i,
  input  logic [wdc_pkg::MONTH_W-1:0]   start_month_i,
  input  logic [wdc_pkg::DAY_W-1:0]     start_day_i,
  input  logic [wdc_pkg::YEAR_W-1:0]    end_year_i,
  input  logic [wdc_pkg::MONTH_W-1:0]   end_month_i,
  input  logic [wdc_pkg::DAY_W-1:0]     end_day_i,
  input  logic                          include_end_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [wdc_pkg::COUNT_W-1:0]   work_days_o,
  output logic                          bad_date_o
);
  import wdc_pkg::*;

  localparam logic [YEAR_W-1:0] YearMax = YEAR_W'(MAX_YEAR);
  localparam int unsigned MulW  = YEAR_W + 13;
  localparam int unsigned Mul7W = SUM_W + 18;

  // captured word
  logic [YEAR_W-1:0]  sy_q, ey_q;
  logic [MONTH_W-1:0] sm_q, em_q;
  logic [DAY_W-1:0]   sd_q, ed_q;
  logic               inc_q;

  // arithmetic
  logic [Q100_W-1:0] q100_q;
  logic [YEAR_W-1:0] yy_q;
  logic [SUM_W-1:0]  sum_q;
  logic [Q7_W-1:0]   q7_q;

  // walk
  logic [YEAR_W-1:0]  cur_year_q;
  logic [MONTH_W-1:0] cur_month_q;
  logic [DAY_W-1:0]   cur_day_q;
  logic [WDAY_W-1:0]  wday_q;
  logic [1:0]         cur_y4_q;
  logic [6:0]         cur_y100_q;
  logic [8:0]         cur_y400_q;
  logic [COUNT_W-1:0] tally_q;
  logic               lt_q;

  // control state
  logic              bad_q;
  logic              out_valid_q;
  logic [MASK_W-1:0] mask_q;
  logic [COUNT_W-1:0] work_days_q;
  logic               bad_date_q;

  // year / 100 by reciprocal
  logic [YEAR_W-1:0] mul_in;
  logic [MulW-1:0]   mul_prod;
  logic              start_early;
  logic [YEAR_W-1:0] yy;

  always_comb begin
    start_early = (sm_q <= MONTH_FEB);
    yy          = sy_q - YEAR_W'(start_early);
    case (cmd_i)
      CMD_QUOT_END:  mul_in = ey_q;
      CMD_QUOT_WDAY: mul_in = yy;
      default:       mul_in = sy_q;
    endcase
    mul_prod = MulW'(mul_in) * MulW'(RECIP_100);
  end

  // date check for start or end, using the stored quotient
  logic [YEAR_W-1:0]  chk_year;
  logic [MONTH_W-1:0] chk_month;
  logic [DAY_W-1:0]   chk_day;
  logic [YEAR_W-1:0]  chk_rem;
  logic [6:0]         r100;
  logic [8:0]         r400;
  logic               chk_leap;
  logic [DAY_W-1:0]   chk_len;
  logic               chk_ok;

  always_comb begin
    chk_year  = (cmd_i == CMD_CHECK_END) ? ey_q : sy_q;
    chk_month = (cmd_i == CMD_CHECK_END) ? em_q : sm_q;
    chk_day   = (cmd_i == CMD_CHECK_END) ? ed_q : sd_q;
    chk_rem   = chk_year - YEAR_W'(q100_q) * YEAR_W'(100);
    r100      = chk_rem[6:0];
    r400      = 9'(r100) + 9'(q100_q[1:0]) * 9'd100;
    chk_leap  = (chk_year[1:0] == 2'd0) && ((r100 != 7'd0) || (r400 == 9'd0));
    chk_len   = month_days(chk_month, chk_leap);
    chk_ok    = (chk_year != '0) && (chk_year <= YearMax)
              && (chk_day != '0) && (chk_day <= chk_len);
  end

  // weekday sum and its reduction mod 7
  logic [SUM_W-1:0] wsum;
  logic [Mul7W-1:0] mul7_prod;
  logic [SUM_W-1:0] r7;

  always_comb begin
    wsum = SUM_W'(sd_q) + SUM_W'(yy_q) + SUM_W'(yy_q >> 2) - SUM_W'(q100_q)
         + SUM_W'(q100_q >> 2) + SUM_W'(month_offset(sm_q));
    mul7_prod = Mul7W'(sum_q) * Mul7W'(RECIP_7);
    r7        = sum_q - SUM_W'(q7_q) * SUM_W'(7);
  end

  // one calendar day forward
  logic               cur_leap;
  logic [DAY_W-1:0]   cur_len;
  logic               at_end;
  logic               workday;

  always_comb begin
    cur_leap = (cur_y4_q == 2'd0) && ((cur_y100_q != 7'd0) || (cur_y400_q == 9'd0));
    cur_len  = month_days(cur_month_q, cur_leap);
    at_end   = (cur_year_q == ey_q) && (cur_month_q == em_q) && (cur_day_q == ed_q);
    workday  = !mask_q[wday_q];
  end

  assign status_o.bad       = bad_q;
  assign status_o.walk_done = at_end || !lt_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= WEEKEND_RESET;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) mask_q <= cfg_wdata_i;
      if (cmd_i == CMD_LOAD) begin
        bad_q <= 1'b0;
      end else if ((cmd_i == CMD_CHECK_START || cmd_i == CMD_CHECK_END) && !chk_ok) begin
        bad_q <= 1'b1;
      end
      if (cmd_i == CMD_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        sy_q    <= start_year_i;
        sm_q    <= start_month_i;
        sd_q    <= start_day_i;
        ey_q    <= end_year_i;
        em_q    <= end_month_i;
        ed_q    <= end_day_i;
        inc_q   <= include_end_i;
        tally_q <= '0;
      end
      CMD_QUOT_START, CMD_QUOT_END: begin
        q100_q <= mul_prod[RECIP_100_SHIFT +: Q100_W];
      end
      CMD_CHECK_START: begin
        cur_y4_q   <= sy_q[1:0];
        cur_y100_q <= r100;
        cur_y400_q <= r400;
      end
      CMD_QUOT_WDAY: begin
        q100_q <= mul_prod[RECIP_100_SHIFT +: Q100_W];
        yy_q   <= yy;
      end
      CMD_SUM_WDAY: begin
        sum_q <= wsum;
      end
      CMD_MOD_WDAY: begin
        q7_q <= mul7_prod[RECIP_7_SHIFT +: Q7_W];
      end
      CMD_INIT_WALK: begin
        wday_q      <= r7[WDAY_W-1:0];
        cur_year_q  <= sy_q;
        cur_month_q <= sm_q;
        cur_day_q   <= sd_q;
        lt_q        <= {sy_q, sm_q, sd_q} < {ey_q, em_q, ed_q};
      end
      CMD_STEP: begin
        if (workday && tally_q != COUNT_MAX) tally_q <= tally_q + COUNT_W'(1);
        wday_q <= (wday_q == WDAY_SAT) ? '0 : wday_q + WDAY_W'(1);
        if (cur_day_q == cur_len) begin
          cur_day_q <= DAY_W'(1);
          if (cur_month_q == MONTH_DEC) begin
            cur_month_q <= MONTH_W'(1);
            cur_year_q  <= cur_year_q + YEAR_W'(1);
            cur_y4_q    <= cur_y4_q + 2'd1;
            cur_y100_q  <= (cur_y100_q == 7'd99) ? 7'd0 : cur_y100_q + 7'd1;
            cur_y400_q  <= (cur_y400_q == 9'd399) ? 9'd0 : cur_y400_q + 9'd1;
          end else begin
            cur_month_q <= cur_month_q + MONTH_W'(1);
          end
        end else begin
          cur_day_q <= cur_day_q + DAY_W'(1);
        end
      end
      CMD_FINISH: begin
        bad_date_q <= bad_q;
        if (bad_q) begin
          work_days_q <= '0;
        end else if (inc_q && tally_q != COUNT_MAX) begin
          work_days_q <= tally_q + COUNT_W'(1);
        end else begin
          work_days_q <= tally_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign work_days_o = work_days_q;
  assign bad_date_o  = bad_date_q;

endmodule

// File: sv/workday_count_between_dates.sv
// top level: counts workdays between two gregorian dates
//
//   channel   dir   handshake        word
//   date_i    in    valid / ready    start and end date, include_end
//   result_o  out   valid / ready    work_days, bad_date
//   cfg       in    cfg_we_i         weekend_mask, 7 bits
//
// a word's result follows its acceptance after the date checks, the weekday
// computation and the day walk over the n days from start to end (n is 0 when
// start is not before end); the walk steps one calendar day per cycle.
// a word with an invalid date skips the weekday computation and the walk.
// one word is worked on at a time; the next is taken once the result sits in
// the output register, which holds it until the sink takes it.
// reset clears the sequencer and the output valid and loads weekend_mask with
// friday and saturday.
module workday_count_between_dates #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  wdc_date_if.sink                   date_i,
  wdc_result_if.source               result_o,
  input  logic                       cfg_we_i,
  input  logic [wdc_pkg::MASK_W-1:0] cfg_wdata_i
);
  import wdc_pkg::*;

  dp_cmd_e    cmd;     // one operation per cycle for the datapath
  dp_status_t status;  // check, walk and output-slot status back to the sequencer
  logic       in_ready;

  assign date_i.ready = in_ready;

  // sequencer: check both dates, derive the start weekday, then walk the days; a bad date skips to the result
  wdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (date_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: captured word, reciprocal dividers, calendar stepper, result register
  wdc_datapath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_year_i  (date_i.start_year),
    .start_month_i (date_i.start_month),
    .start_day_i   (date_i.start_day),
    .end_year_i    (date_i.end_year),
    .end_month_i   (date_i.end_month),
    .end_day_i     (date_i.end_day),
    .include_end_i (date_i.include_end),
    .out_ready_i   (result_o.ready),
    .out_valid_o   (result_o.valid),
    .work_days_o   (result_o.work_days),
    .bad_date_o    (result_o.bad_date)
  );

endmodule
